[hdl/keyed_multi_channel_fifo_core_assert.svh]
`ifndef KEYED_MULTI_CHANNEL_FIFO_CORE_ASSERT_SVH
`define KEYED_MULTI_CHANNEL_FIFO_CORE_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define KMCF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define KMCF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/kmcf_pkg.sv]
`timescale 1ns / 1ps

package kmcf_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int DEPTH_DEF    = 16;
    localparam int TOPIC_BYTES  = 8;
    localparam int USER_BYTES   = 4;

    localparam int TOPIC_W     = 64;
    localparam int USER_W      = 32;
    localparam int WEIGHT_W    = 32;
    localparam int CMD_W       = 3;
    localparam int CH_FIELD_W  = 3;
    localparam int STATUS_W    = 3;
    localparam int CFG_CH_W    = 4;
    localparam int CFG_DEPTH_W = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_IDX_W   = 1;

    localparam logic [TOPIC_W-1:0] TOPIC_MASK = (TOPIC_BYTES >= 8) ? {TOPIC_W{1'b1}} :
        TOPIC_W'((64'd1 << (8 * TOPIC_BYTES)) - 64'd1);
    localparam logic [USER_W-1:0] USER_MASK = (USER_BYTES >= 4) ? {USER_W{1'b1}} :
        USER_W'((64'd1 << (8 * USER_BYTES)) - 64'd1);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_CH    = 3'd0,
        CMD_READ_CH     = 3'd1,
        CMD_WRITE_USER  = 3'd2,
        CMD_READ_USER   = 3'd3,
        CMD_LOOKUP_USER = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_NOUSER = 3'd3,
        ST_BADCH  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS = 1'b0,
        CFG_DEPTH    = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_READ
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        logic [TOPIC_W-1:0]  topic;
        logic [USER_W-1:0]   user;
        logic [WEIGHT_W-1:0] weight;
    } t_tuple;

endpackage

[hdl/kmcf_user_map.sv]
`timescale 1ns / 1ps

module kmcf_user_map #(
    parameter int CHANNELS = kmcf_pkg::CHANNELS_DEF,
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int CNT_W = $clog2(CHANNELS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_commit,
    input  logic [kmcf_pkg::USER_W-1:0] i_key,
    input  logic [CNT_W-1:0]            i_active,
    output logic                        o_found,
    output logic [CH_W-1:0]             o_ch
);
    import kmcf_pkg::*;

    logic [USER_W-1:0] r_map [CHANNELS];
    logic [CNT_W-1:0]  r_used;
    logic              done;
    logic              found;
    logic              grant;
    logic [CH_W-1:0]   sel;

    // first slot that is free or holds the key, in slot order
    always_comb begin
        done  = 1'b0;
        found = 1'b0;
        grant = 1'b0;
        sel   = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (!done && (i < int'(i_active))) begin
                if (r_map[i] == '0) begin
                    done = 1'b1;
                    sel  = CH_W'(i);
                    if (32'(r_used) < 32'(i_active)) begin
                        found = 1'b1;
                        grant = 1'b1;
                    end
                end else if (r_map[i] == i_key) begin
                    done  = 1'b1;
                    sel   = CH_W'(i);
                    found = 1'b1;
                end
            end
        end
        if (i_key == '0) begin
            found = 1'b0;
            grant = 1'b0;
        end
        o_found = found;
        o_ch    = found ? sel : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_map[i] <= '0;
            end
            r_used <= '0;
        end else if (i_commit && grant) begin
            r_map[sel] <= i_key;
            r_used     <= r_used + CNT_W'(1);
        end
    end

endmodule

[hdl/kmcf_ptr_ram.sv]
`timescale 1ns / 1ps

module kmcf_ptr_ram #(
    parameter int CHANNELS = kmcf_pkg::CHANNELS_DEF,
    parameter int WIDTH    = 13,
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_re,
    input  logic [CH_W-1:0]  i_raddr,
    input  logic             i_we,
    input  logic [CH_W-1:0]  i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    import kmcf_pkg::*;

    logic [WIDTH-1:0]    r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    logic [WIDTH-1:0]    r_rdata;

    // an entry never written reads as all pointers and count at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/kmcf_tuple_ram.sv]
`timescale 1ns / 1ps

module kmcf_tuple_ram #(
    parameter int CHANNELS = kmcf_pkg::CHANNELS_DEF,
    parameter int DEPTH    = kmcf_pkg::DEPTH_DEF,
    localparam int ENTRIES = CHANNELS * DEPTH,
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  kmcf_pkg::t_tuple i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output kmcf_pkg::t_tuple o_rdata
);
    import kmcf_pkg::*;

    t_tuple r_mem [ENTRIES];
    t_tuple r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/keyed_multi_channel_fifo_core.sv]
`timescale 1ns / 1ps
// channel     handshake                       payload
// config      i_cfg_we                        i_cfg_index, i_cfg_data
// input       i_in_valid / o_in_ready         i_command .. i_weight_in
// output      o_out_valid / i_out_ready       o_status .. o_weight_out
//
// write, lookup, refused and empty-read commands finish in the check state, reads of a tuple
// go on to a read state; the registered read of the pointer memory, then of the tuple memory, sets these steps
// one transaction is in flight at a time; the next is taken once the block is idle
// a result waits in the output register; a full register stalls the block
// synchronous active-low reset; valid bits cover the pointer memory, no clearing pass

`include "keyed_multi_channel_fifo_core_assert.svh"

module keyed_multi_channel_fifo_core #(
    parameter int CHANNELS = kmcf_pkg::CHANNELS_DEF,
    parameter int DEPTH    = kmcf_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kmcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kmcf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [kmcf_pkg::CMD_W-1:0]       i_command,
    input  logic [kmcf_pkg::CH_FIELD_W-1:0]  i_channel,
    input  logic [kmcf_pkg::USER_W-1:0]      i_user_key,
    input  logic [kmcf_pkg::TOPIC_W-1:0]     i_topic_in,
    input  logic [kmcf_pkg::USER_W-1:0]      i_tuple_user_in,
    input  logic signed [kmcf_pkg::WEIGHT_W-1:0] i_weight_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [kmcf_pkg::STATUS_W-1:0]    o_status,
    output logic [kmcf_pkg::CH_FIELD_W-1:0]  o_channel_out,
    output logic [kmcf_pkg::TOPIC_W-1:0]     o_topic_out,
    output logic [kmcf_pkg::USER_W-1:0]      o_tuple_user_out,
    output logic signed [kmcf_pkg::WEIGHT_W-1:0] o_weight_out
);
    import kmcf_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(CHANNELS + 1);
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int PREC_W = 2 * PTR_W + FILL_W;
    localparam int TA_W   = (CHANNELS * DEPTH > 1) ? $clog2(CHANNELS * DEPTH) : 1;

    logic [CFG_CH_W-1:0]    r_cfg_ch;
    logic [CFG_DEPTH_W-1:0] r_cfg_depth;
    logic [CNT_W-1:0]       active_ch;
    logic [FILL_W-1:0]      active_depth;

    t_state r_state, n_state;
    t_op    r_op;
    t_status r_status;
    logic [CH_W-1:0] r_ch;
    t_tuple r_tuple;

    logic      in_acc;
    logic      user_cmd;
    logic      map_found;
    logic [CH_W-1:0] map_ch;
    t_op       d_op;
    t_status   d_status;
    logic [CH_W-1:0] d_ch;

    logic              ptr_re;
    logic              ptr_we;
    logic [PREC_W-1:0] ptr_wdata;
    logic [PREC_W-1:0] ptr_rdata;
    logic [PTR_W-1:0]  p_rp, p_wp;
    logic [FILL_W-1:0] p_fill;

    logic              tup_we, tup_re;
    logic [TA_W-1:0]   tup_waddr, tup_raddr;
    t_tuple            tup_rdata;

    logic              out_free;
    logic              out_load;
    t_status           out_status;
    t_tuple            out_tuple;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [CH_FIELD_W-1:0] r_out_ch;
    t_tuple            r_out_tuple;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                  input logic [FILL_W-1:0] d);
        return (32'(p) + 32'd1 >= 32'(d)) ? '0 : p + PTR_W'(1);
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ch    <= CFG_CH_W'(8);
            r_cfg_depth <= CFG_DEPTH_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHANNELS: r_cfg_ch    <= i_cfg_data[CFG_CH_W-1:0];
                CFG_DEPTH:    r_cfg_depth <= i_cfg_data[CFG_DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_ch == '0) begin
            active_ch = CNT_W'(1);
        end else if (32'(r_cfg_ch) > 32'(CHANNELS)) begin
            active_ch = CNT_W'(CHANNELS);
        end else begin
            active_ch = CNT_W'(r_cfg_ch);
        end
        if (r_cfg_depth == '0) begin
            active_depth = FILL_W'(1);
        end else if (32'(r_cfg_depth) > 32'(DEPTH)) begin
            active_depth = FILL_W'(DEPTH);
        end else begin
            active_depth = FILL_W'(r_cfg_depth);
        end
    end

    // command decode and channel resolution at accept
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign user_cmd   = (i_command inside {CMD_WRITE_USER, CMD_READ_USER, CMD_LOOKUP_USER});

    kmcf_user_map #(
        .CHANNELS (CHANNELS)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (in_acc && user_cmd),
        .i_key    (i_user_key & USER_MASK),
        .i_active (active_ch),
        .o_found  (map_found),
        .o_ch     (map_ch)
    );

    always_comb begin
        d_op     = OP_NONE;
        d_status = ST_BADCH;
        d_ch     = '0;
        case (i_command)
            CMD_WRITE_CH, CMD_READ_CH: begin
                if (32'(i_channel) < 32'(active_ch)) begin
                    d_status = ST_OK;
                    d_ch     = CH_W'(i_channel);
                    d_op     = (i_command == CMD_WRITE_CH) ? OP_WRITE : OP_READ;
                end
            end
            CMD_WRITE_USER, CMD_READ_USER, CMD_LOOKUP_USER: begin
                if (!map_found) begin
                    d_status = ST_NOUSER;
                end else begin
                    d_status = ST_OK;
                    d_ch     = map_ch;
                    case (i_command)
                        CMD_WRITE_USER: d_op = OP_WRITE;
                        CMD_READ_USER:  d_op = OP_READ;
                        default:        d_op = OP_NONE;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status       <= d_status;
            r_ch           <= d_ch;
            r_tuple.topic  <= i_topic_in & TOPIC_MASK;
            r_tuple.user   <= i_tuple_user_in & USER_MASK;
            r_tuple.weight <= i_weight_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_op <= d_op;
            end
        end
    end

    // pointer state memory: read pointer, write pointer, fill count
    assign ptr_re = in_acc && (d_op != OP_NONE);
    assign {p_rp, p_wp, p_fill} = ptr_rdata;

    kmcf_ptr_ram #(
        .CHANNELS (CHANNELS),
        .WIDTH    (PREC_W)
    ) u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (ptr_re),
        .i_raddr (d_ch),
        .i_we    (ptr_we),
        .i_waddr (r_ch),
        .i_wdata (ptr_wdata),
        .o_rdata (ptr_rdata)
    );

    assign tup_waddr = TA_W'(32'(r_ch) * DEPTH + 32'(p_wp));
    assign tup_raddr = TA_W'(32'(r_ch) * DEPTH + 32'(p_rp));

    kmcf_tuple_ram #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_tuple (
        .i_clk   (i_clk),
        .i_we    (tup_we),
        .i_waddr (tup_waddr),
        .i_wdata (r_tuple),
        .i_re    (tup_re),
        .i_raddr (tup_raddr),
        .o_rdata (tup_rdata)
    );

    // sequencer
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        ptr_we     = 1'b0;
        ptr_wdata  = ptr_rdata;
        tup_we     = 1'b0;
        tup_re     = 1'b0;
        out_load   = 1'b0;
        out_status = r_status;
        out_tuple  = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (r_op)
                    OP_WRITE: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                            if (32'(p_fill) >= 32'(active_depth)) begin
                                out_status = ST_FULL;
                            end else begin
                                tup_we    = 1'b1;
                                ptr_we    = 1'b1;
                                ptr_wdata = {p_rp, step_ptr(p_wp, active_depth),
                                             p_fill + FILL_W'(1)};
                            end
                        end
                    end
                    OP_READ: begin
                        if (p_fill == '0) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            tup_re    = 1'b1;
                            ptr_we    = 1'b1;
                            ptr_wdata = {step_ptr(p_rp, active_depth), p_wp,
                                         p_fill - FILL_W'(1)};
                            n_state   = S_READ;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_tuple = tup_rdata;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= out_status;
            r_out_ch     <= CH_FIELD_W'(r_ch);
            r_out_tuple  <= out_tuple;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_channel_out    = r_out_ch;
    assign o_topic_out      = r_out_tuple.topic;
    assign o_tuple_user_out = r_out_tuple.user;
    assign o_weight_out     = signed'(r_out_tuple.weight);

    `KMCF_ASSERT_NXT(a_acc_to_check, i_clk, i_rst_n, in_acc, r_state == S_CHECK,
        "accepted transaction did not reach the check state")
    `KMCF_ASSERT_IMP(a_read_from_check, i_clk, i_rst_n,
        (r_state == S_READ) && ($past(r_state) != S_READ),
        ($past(r_state) == S_CHECK) && ($past(r_op) == OP_READ),
        "tuple read state entered without a read transaction")
    `KMCF_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid),
        ($past(r_state) == S_CHECK) || ($past(r_state) == S_READ),
        "result produced while no transaction was in flight")
    `KMCF_ASSERT_IMP(a_tuple_write_ok, i_clk, i_rst_n, tup_we,
        ptr_we && (r_op == OP_WRITE) && (32'(p_fill) < 32'(active_depth)),
        "tuple store written without a matching pointer update")

endmodule

[test/keyed_multi_channel_fifo_core_tb.sv]
`timescale 1ns / 1ps

module keyed_multi_channel_fifo_core_tb;
    import kmcf_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic [CH_FIELD_W-1:0]      channel;
        logic [USER_W-1:0]          user_key;
        logic [TOPIC_W-1:0]         topic;
        logic [USER_W-1:0]          tuple_user;
        logic signed [WEIGHT_W-1:0] weight;
    } t_fifo_command;

    typedef struct packed {
        t_status                status;
        logic [CH_FIELD_W-1:0]  channel;
        t_tuple                 data;
    } t_fifo_result;

    class t_channel_fifo_mirror;
        logic [CFG_CH_W-1:0]    channels_reg;
        logic [CFG_DEPTH_W-1:0] depth_reg;
        t_tuple                 ring [CHANNELS_DEF * DEPTH_DEF];
        bit                     ring_written [CHANNELS_DEF * DEPTH_DEF];
        int unsigned            rd_ptr [CHANNELS_DEF];
        int unsigned            wr_ptr [CHANNELS_DEF];
        int unsigned            fill [CHANNELS_DEF];
        logic [USER_W-1:0]      owner [CHANNELS_DEF];
        int unsigned            owners;
        t_fifo_result           expected_results [$];
        int                     mismatches;

        function new();
            channels_reg = CFG_CH_W'(CHANNELS_DEF);
            depth_reg = CFG_DEPTH_W'(DEPTH_DEF);
            for (int i = 0; i < CHANNELS_DEF * DEPTH_DEF; i++) begin
                ring[i] = '0;
                ring_written[i] = 1'b0;
            end
            for (int i = 0; i < CHANNELS_DEF; i++) begin
                rd_ptr[i] = 0;
                wr_ptr[i] = 0;
                fill[i] = 0;
                owner[i] = '0;
            end
            owners = 0;
            mismatches = 0;
        endfunction

        function void set_register(t_cfg_reg index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_CHANNELS) begin
                channels_reg = value[CFG_CH_W-1:0];
            end else begin
                depth_reg = value[CFG_DEPTH_W-1:0];
            end
        endfunction

        function int unsigned live_channels();
            if (channels_reg < 1) return 1;
            if (channels_reg > CHANNELS_DEF) return CHANNELS_DEF;
            return channels_reg;
        endfunction

        function int unsigned live_depth();
            if (depth_reg < 1) return 1;
            if (depth_reg > DEPTH_DEF) return DEPTH_DEF;
            return depth_reg;
        endfunction

        function int unsigned next_ptr(int unsigned p);
            return (p + 1 >= live_depth()) ? 0 : p + 1;
        endfunction

        // slot of a user id, taking the first free one when claim is set
        function int user_channel(logic [USER_W-1:0] key, bit claim);
            int unsigned n;
            logic [USER_W-1:0] id;
            n = live_channels();
            id = key & USER_MASK;
            if (id == '0) return -1;
            for (int i = 0; i < n; i++) begin
                if (owner[i] == '0) begin
                    if (owners >= n) return -1;
                    if (claim) begin
                        owner[i] = id;
                        owners++;
                    end
                    return i;
                end
                if (owner[i] == id) return i;
            end
            return -1;
        endfunction

        function int target_channel(t_fifo_command cmd, bit claim);
            case (cmd.command)
                CMD_WRITE_CH, CMD_READ_CH:
                    return (cmd.channel < live_channels()) ? int'(cmd.channel) : -1;
                CMD_WRITE_USER, CMD_READ_USER, CMD_LOOKUP_USER:
                    return user_channel(cmd.user_key, claim);
                default:
                    return -1;
            endcase
        endfunction

        function bit reads_unwritten(t_fifo_command cmd);
            int ch;
            if (cmd.command != CMD_READ_CH && cmd.command != CMD_READ_USER) return 1'b0;
            ch = target_channel(cmd, 1'b0);
            if (ch < 0 || fill[ch] == 0) return 1'b0;
            return !ring_written[ch * DEPTH_DEF + rd_ptr[ch] % DEPTH_DEF];
        endfunction

        function void note_command(t_fifo_command cmd);
            t_fifo_result res;
            int ch;
            int unsigned addr;
            res = '0;
            ch = target_channel(cmd, 1'b1);
            if (ch < 0) begin
                if (cmd.command == CMD_WRITE_USER || cmd.command == CMD_READ_USER ||
                    cmd.command == CMD_LOOKUP_USER) begin
                    res.status = ST_NOUSER;
                end else begin
                    res.status = ST_BADCH;
                end
            end else begin
                res.channel = CH_FIELD_W'(ch);
                if (cmd.command == CMD_WRITE_CH || cmd.command == CMD_WRITE_USER) begin
                    if (fill[ch] >= live_depth()) begin
                        res.status = ST_FULL;
                    end else begin
                        addr = ch * DEPTH_DEF + wr_ptr[ch] % DEPTH_DEF;
                        ring[addr].topic = cmd.topic & TOPIC_MASK;
                        ring[addr].user = cmd.tuple_user & USER_MASK;
                        ring[addr].weight = cmd.weight;
                        ring_written[addr] = 1'b1;
                        fill[ch]++;
                        wr_ptr[ch] = next_ptr(wr_ptr[ch]);
                        res.status = ST_OK;
                    end
                end else if (cmd.command == CMD_READ_CH || cmd.command == CMD_READ_USER) begin
                    if (fill[ch] == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        addr = ch * DEPTH_DEF + rd_ptr[ch] % DEPTH_DEF;
                        res.data = ring[addr];
                        fill[ch]--;
                        rd_ptr[ch] = next_ptr(rd_ptr[ch]);
                        res.status = ST_OK;
                    end
                end else begin
                    res.status = ST_OK;
                end
            end
            expected_results.push_back(res);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 60)
                    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic [CH_FIELD_W-1:0] channel, t_tuple data);
            t_fifo_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual status %0h channel %0h",
                         $time, status, channel);
                return;
            end
            want = expected_results.pop_front();
            compare("status", want.status, status);
            compare("channel", want.channel, channel);
            compare("topic", want.data.topic, data.topic);
            compare("tuple user", want.data.user, data.user);
            compare("weight", want.data.weight, data.weight);
        endfunction
    endclass

    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int POOL         = 10;
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_LOOKUP_USER + 1);
    localparam logic [CMD_W-1:0] CMD_MAX          = {CMD_W{1'b1}};

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [CMD_W-1:0]           i_command = '0;
    logic [CH_FIELD_W-1:0]      i_channel = '0;
    logic [USER_W-1:0]          i_user_key = '0;
    logic [TOPIC_W-1:0]         i_topic_in = '0;
    logic [USER_W-1:0]          i_tuple_user_in = '0;
    logic signed [WEIGHT_W-1:0] i_weight_in = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic [CH_FIELD_W-1:0]      o_channel_out;
    logic [TOPIC_W-1:0]         o_topic_out;
    logic [USER_W-1:0]          o_tuple_user_out;
    logic signed [WEIGHT_W-1:0] o_weight_out;

    t_channel_fifo_mirror mirror = new();

    bit no_idle = 1'b0;
    bit hold_request = 1'b0;
    int send_gap_pct = 20;
    int recv_gap_pct = 20;
    int quiet_cycles = 0;
    logic [USER_W-1:0] known_users [POOL];

    logic [CFG_DATA_W-1:0] phase_channels [PHASES] = '{8, 1, 19, 12, 8, 0, 5, 8};
    logic [CFG_DATA_W-1:0] phase_depth [PHASES]    = '{16, 1, 4, 20, 2, 0, 31, 7};
    int phase_write_pct [PHASES] = '{70, 50, 60, 40, 55, 50, 65, 50};
    int phase_send_gap [PHASES]  = '{30, 0, 20, 50, 10, 25, 15, 0};
    int phase_recv_gap [PHASES]  = '{30, 20, 0, 50, 10, 25, 15, 0};

    keyed_multi_channel_fifo_core dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            mirror.check_result(o_status, o_channel_out,
                                t_tuple'({o_topic_out, o_tuple_user_out, o_weight_out}));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("keyed_multi_channel_fifo_core_tb: errors");
            $finish;
        end
    end

    // result side: random stall bursts and one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!no_idle && $urandom_range(99) < recv_gap_pct) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic t_fifo_command make_command(logic [CMD_W-1:0] op,
                                                   logic [CH_FIELD_W-1:0] ch = '0,
                                                   logic [USER_W-1:0] key = '0,
                                                   logic [TOPIC_W-1:0] topic = '0,
                                                   logic [USER_W-1:0] tuple_user = '0,
                                                   logic [WEIGHT_W-1:0] weight = '0);
        t_fifo_command c;
        c.command = op;
        c.channel = ch;
        c.user_key = key;
        c.topic = topic;
        c.tuple_user = tuple_user;
        c.weight = weight;
        return c;
    endfunction

    function automatic t_fifo_command random_command(int write_pct);
        t_fifo_command c;
        int unsigned roll;
        bit by_user;
        bit is_write;
        if ($urandom_range(9) < 8)
            c.channel = CH_FIELD_W'($urandom_range(mirror.live_channels() - 1));
        else
            c.channel = CH_FIELD_W'($urandom);
        c.user_key = ($urandom_range(9) == 0) ? USER_W'($urandom)
                                             : known_users[$urandom_range(POOL - 1)];
        c.topic = {$urandom, $urandom};
        c.tuple_user = $urandom;
        c.weight = $urandom;
        roll = $urandom_range(99);
        by_user = $urandom_range(1);
        is_write = $urandom_range(99) < write_pct;
        if (roll < 4)
            c.command = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_MAX));
        else if (roll < 12)
            c.command = CMD_LOOKUP_USER;
        else if (is_write)
            c.command = by_user ? CMD_WRITE_USER : CMD_WRITE_CH;
        else
            c.command = by_user ? CMD_READ_USER : CMD_READ_CH;
        // steer away from entries that were never stored
        if (mirror.reads_unwritten(c))
            c.command = (c.command == CMD_READ_CH) ? CMD_WRITE_CH : CMD_WRITE_USER;
        return c;
    endfunction

    task automatic send_command(t_fifo_command cmd);
        if (!no_idle && $urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_command = cmd.command;
        i_channel = cmd.channel;
        i_user_key = cmd.user_key;
        i_topic_in = cmd.topic;
        i_tuple_user_in = cmd.tuple_user;
        i_weight_in = cmd.weight;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        mirror.note_command(cmd);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (mirror.expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg index, logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(posedge i_clk);
        mirror.set_register(index, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        known_users[0] = '1;
        known_users[1] = USER_W'(1);
        for (int i = 2; i < POOL - 1; i++) known_users[i] = $urandom_range(2, 32'hFFFF_FFFF);
        known_users[POOL - 1] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fifo extremes on the default setup
        send_command(make_command(CMD_READ_CH, 0));
        send_command(make_command(CMD_WRITE_CH, 0, '0, '1, '1, 32'h8000_0000));
        send_command(make_command(CMD_WRITE_CH, 0, '0, '0, '0, 32'h7FFF_FFFF));
        send_command(make_command(CMD_READ_CH, 0));
        send_command(make_command(CMD_READ_CH, 0));
        send_command(make_command(CMD_WRITE_CH, 7, '0, 64'h0123_4567_89AB_CDEF,
                                  32'h5A5A_A5A5, 32'hFFFF_FFFF));
        send_command(make_command(CMD_READ_CH, 7));
        // zero user id, map assignment, unknown commands
        send_command(make_command(CMD_LOOKUP_USER, 0, '0));
        send_command(make_command(CMD_WRITE_USER, 0, '0, '1, '1, '1));
        send_command(make_command(CMD_LOOKUP_USER, 0, '1));
        send_command(make_command(CMD_WRITE_USER, 0, USER_W'(1), 64'hFEDC_BA98_7654_3210,
                                  32'h1234_5678, 32'h8765_4321));
        send_command(make_command(CMD_READ_USER, 0, USER_W'(1)));
        send_command(make_command(CMD_READ_USER, 0, '1));
        send_command(make_command(CMD_FIRST_UNUSED, 0));
        send_command(make_command(CMD_MAX, 7));
        // fewer channels: bad channel and map full
        write_register(CFG_CHANNELS, 2);
        send_command(make_command(CMD_WRITE_CH, 2));
        send_command(make_command(CMD_LOOKUP_USER, 0, USER_W'(5)));
        write_register(CFG_CHANNELS, 0);
        send_command(make_command(CMD_READ_CH, 1));
        // depth of one
        write_register(CFG_CHANNELS, 8);
        write_register(CFG_DEPTH, 1);
        send_command(make_command(CMD_WRITE_CH, 3, '0, '1, '0, '1));
        send_command(make_command(CMD_WRITE_CH, 3));
        send_command(make_command(CMD_READ_CH, 3));
        // depth lowered while tuples are held
        write_register(CFG_DEPTH, 16);
        for (int i = 0; i < 3; i++)
            send_command(make_command(CMD_WRITE_CH, 4, '0, {$urandom, $urandom},
                                      $urandom, $urandom));
        write_register(CFG_DEPTH, 2);
        send_command(make_command(CMD_WRITE_CH, 4));
        for (int i = 0; i < 3; i++) send_command(make_command(CMD_READ_CH, 4));

        for (int p = 0; p < PHASES; p++) begin
            write_register(CFG_CHANNELS, phase_channels[p]);
            write_register(CFG_DEPTH, phase_depth[p]);
            send_gap_pct = phase_send_gap[p];
            recv_gap_pct = phase_recv_gap[p];
            no_idle = (p == PHASES - 1);
            if (p == 0) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_command(random_command(phase_write_pct[p]));
        end

        wait_idle();
        if (mirror.mismatches == 0) begin
            $display("keyed_multi_channel_fifo_core_tb: clean");
        end else begin
            $display("keyed_multi_channel_fifo_core_tb: errors");
        end
        $finish;
    end

endmodule
